@@ src/lvb_pkg.sv @@
// Shared types, constants and label tables for the label/value block parser.
package lvb_pkg;

  // Default limits on stored label and value characters
  localparam int MAX_VALUE_CHARS_DEF = 31;
  localparam int MAX_LABEL_CHARS_DEF = 31;

  // Label candidates: V, I, VS, SOC, TTG, Checksum
  localparam int CAND_COUNT    = 6;
  localparam int CAND_CHECKSUM = 5;
  localparam int CAND_CHARS    = 8;

  // Value slots, in candidate order
  localparam int SLOT_COUNT = 5;
  localparam int SLOT_V     = 0;
  localparam int SLOT_I     = 1;
  localparam int SLOT_VS    = 2;
  localparam int SLOT_SOC   = 3;
  localparam int SLOT_TTG   = 4;

  typedef logic [7:0] char_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_VT    = 8'h0B;
  localparam char_t CH_FF    = 8'h0C;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SP    = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;

  localparam char_t CAND_TEXT [CAND_COUNT][CAND_CHARS] = '{
    '{"V", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"I", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"V", "S", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"S", "O", "C", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"T", "T", "G", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"C", "h", "e", "c", "k", "s", "u", "m"}
  };

  localparam logic [3:0] CAND_LEN [CAND_COUNT] = '{4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd8};

  localparam logic [31:0] MAG_LIMIT   = 32'h8000_0000;
  localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] TTG_UNKNOWN = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_LABEL = 2'd0,
    PH_VALUE = 2'd1,
    PH_CHECK = 2'd2
  } parse_phase_t;

  typedef enum logic [1:0] {
    NUM_WS   = 2'd0,
    NUM_DIG  = 2'd1,
    NUM_DONE = 2'd2
  } num_phase_t;

  // Block result handed from the parser to the output stage
  typedef struct packed {
    logic                         ok;
    logic                         valid;
    logic [SLOT_COUNT-1:0][31:0]  vals;
  } lvb_blk_t;

endpackage

@@ src/lvb_in_if.sv @@
// Input channel: one received byte per beat.
interface lvb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ src/lvb_out_if.sv @@
// Output channel: one block result per beat.
interface lvb_out_if;
  logic               valid;
  logic               ready;
  logic               block_ok;
  logic               data_valid;
  logic signed [31:0] voltage_mv;
  logic signed [31:0] current_ma;
  logic signed [31:0] starter_mv;
  logic signed [31:0] soc_permille;
  logic signed [31:0] time_to_go_min;
  logic signed [63:0] power_uw;

  modport source (output valid, output block_ok, output data_valid, output voltage_mv,
                  output current_ma, output starter_mv, output soc_permille,
                  output time_to_go_min, output power_uw, input ready);
  modport sink (input valid, input block_ok, input data_valid, input voltage_mv,
                input current_ma, input starter_mv, input soc_permille,
                input time_to_go_min, input power_uw, output ready);
endinterface

@@ src/lvb_parser.sv @@
// Byte parser: label match, number parse, running sum, pending and kept values.
module lvb_parser
  import lvb_pkg::*;
#(
  parameter int MAX_VALUE_CHARS = MAX_VALUE_CHARS_DEF,
  parameter int MAX_LABEL_CHARS = MAX_LABEL_CHARS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  char_t    rx_byte,
  input  logic     b_ready,
  output logic     a_valid,
  output lvb_blk_t blk
);

  localparam int LW = $clog2(MAX_LABEL_CHARS + 1);
  localparam int VW = $clog2(MAX_VALUE_CHARS + 1);

  // Value slots after reset: all zero, time to go unknown
  localparam logic [SLOT_COUNT-1:0][31:0] VALS_INIT =
    (SLOT_COUNT*32)'(TTG_UNKNOWN) << (SLOT_TTG*32);

  parse_phase_t                 parse_phase, parse_phase_next;
  logic [LW-1:0]                label_len, label_len_next;
  logic [CAND_COUNT-1:0]        label_match, label_match_next;
  num_phase_t                   num_phase, num_phase_next;
  logic                         num_negative, num_negative_next;
  logic [31:0]                  num_accum, num_accum_next;
  logic [VW-1:0]                value_len, value_len_next;
  logic [7:0]                   running_sum, running_sum_next;
  logic [SLOT_COUNT-1:0][31:0]  pending, pending_next;
  logic [SLOT_COUNT-1:0]        present, present_next;
  logic [SLOT_COUNT-1:0][31:0]  kept, kept_next;
  logic                         kept_valid, kept_valid_next;
  logic                         a_ok;
  logic                         is_check;
  logic                         block_ok;

  logic [7:0]                   sum_add;
  logic [CAND_COUNT-1:0]        exact;
  logic [35:0]                  num_t;
  logic [31:0]                  num_val;
  logic                         digit_go;

  // Byte-independent helpers
  always_comb begin
    sum_add = running_sum + rx_byte;
    for (int k = 0; k < CAND_COUNT; k++) begin
      exact[k] = label_match[k] && (label_len == LW'(CAND_LEN[k]));
    end
    num_t = ({4'b0, num_accum} << 3) + ({4'b0, num_accum} << 1) + {28'b0, rx_byte - CH_0};
    num_val = num_negative ? (32'd0 - num_accum)
                           : ((num_accum > POS_MAX) ? POS_MAX : num_accum);
  end

  // Next state for one accepted byte
  always_comb begin
    parse_phase_next  = parse_phase;
    label_len_next    = label_len;
    label_match_next  = label_match;
    num_phase_next    = num_phase;
    num_negative_next = num_negative;
    num_accum_next    = num_accum;
    value_len_next    = value_len;
    running_sum_next  = sum_add;
    pending_next      = pending;
    present_next      = present;
    kept_next         = kept;
    kept_valid_next   = kept_valid;
    is_check          = 1'b0;
    block_ok          = 1'b0;
    digit_go          = 1'b0;

    case (parse_phase)
      PH_LABEL: begin
        if (rx_byte == CH_TAB) begin
          label_match_next = exact;
          label_len_next   = '0;
          if (exact[CAND_CHECKSUM]) begin
            parse_phase_next = PH_CHECK;
          end else begin
            parse_phase_next  = PH_VALUE;
            num_phase_next    = NUM_WS;
            num_negative_next = 1'b0;
            num_accum_next    = '0;
            value_len_next    = '0;
          end
        end else if (rx_byte == CH_LF) begin
          label_len_next   = '0;
          label_match_next = '1;
        end else if (rx_byte != CH_CR && label_len < LW'(MAX_LABEL_CHARS)) begin
          for (int k = 0; k < CAND_COUNT; k++) begin
            if (label_len >= LW'(CAND_LEN[k]) || CAND_TEXT[k][label_len[2:0]] != rx_byte) begin
              label_match_next[k] = 1'b0;
            end
          end
          label_len_next = label_len + 1'b1;
        end
      end

      PH_VALUE: begin
        if (rx_byte == CH_LF) begin
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (label_match[k]) begin
              pending_next[k] = num_val;
              present_next[k] = 1'b1;
            end
          end
          num_phase_next    = NUM_WS;
          num_negative_next = 1'b0;
          num_accum_next    = '0;
          value_len_next    = '0;
          parse_phase_next  = PH_LABEL;
          label_len_next    = '0;
          label_match_next  = '1;
        end else if (rx_byte != CH_CR && value_len < VW'(MAX_VALUE_CHARS)) begin
          value_len_next = value_len + 1'b1;
          // atol-style scan: skip blanks, take one sign, then digits
          case (num_phase)
            NUM_WS: begin
              if (rx_byte inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
                num_phase_next = NUM_WS;
              end else if (rx_byte == CH_MINUS) begin
                num_phase_next    = NUM_DIG;
                num_negative_next = 1'b1;
              end else if (rx_byte == CH_PLUS) begin
                num_phase_next = NUM_DIG;
              end else begin
                digit_go = 1'b1;
              end
            end
            NUM_DIG:  digit_go = 1'b1;
            default:  num_phase_next = num_phase;
          endcase
          if (digit_go) begin
            if (rx_byte inside {[CH_0:CH_9]}) begin
              num_phase_next = NUM_DIG;
              num_accum_next = (num_t > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : num_t[31:0];
            end else begin
              num_phase_next = NUM_DONE;
            end
          end
        end
      end

      PH_CHECK: begin
        is_check = 1'b1;
        block_ok = (sum_add == 8'd0);
        if (block_ok) begin
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (present[k]) begin
              kept_next[k] = pending[k];
            end
          end
          kept_valid_next = 1'b1;
        end
        pending_next           = '0;
        pending_next[SLOT_TTG] = TTG_UNKNOWN;
        present_next           = '0;
        running_sum_next       = '0;
        parse_phase_next       = PH_LABEL;
        label_len_next         = '0;
        label_match_next       = '1;
        num_phase_next         = NUM_WS;
        num_negative_next      = 1'b0;
        num_accum_next         = '0;
        value_len_next         = '0;
      end

      default: begin
        parse_phase_next = PH_LABEL;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase           <= PH_LABEL;
      label_len             <= '0;
      label_match           <= '1;
      num_phase             <= NUM_WS;
      num_negative          <= 1'b0;
      num_accum             <= '0;
      value_len             <= '0;
      running_sum           <= '0;
      pending               <= VALS_INIT;
      present               <= '0;
      kept                  <= VALS_INIT;
      kept_valid            <= 1'b0;
    end else if (take) begin
      parse_phase  <= parse_phase_next;
      label_len    <= label_len_next;
      label_match  <= label_match_next;
      num_phase    <= num_phase_next;
      num_negative <= num_negative_next;
      num_accum    <= num_accum_next;
      value_len    <= value_len_next;
      running_sum  <= running_sum_next;
      pending      <= pending_next;
      present      <= present_next;
      kept         <= kept_next;
      kept_valid   <= kept_valid_next;
    end
  end

  // Block result register; kept values hold while it waits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take && is_check) begin
      a_valid <= 1'b1;
    end else if (b_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_check) begin
      a_ok <= block_ok;
    end
  end

  assign blk = '{ok: a_ok, valid: kept_valid, vals: kept};

endmodule

@@ src/lvb_out_stage.sv @@
// Output register with the power product of the kept voltage and current.
module lvb_out_stage
  import lvb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       a_valid,
  input  lvb_blk_t   blk,
  output logic       b_ready,
  lvb_out_if.source  tx
);

  logic load;

  assign b_ready = !tx.valid || tx.ready;
  assign load    = a_valid && b_ready;

  // Beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (b_ready) begin
      tx.valid <= a_valid;
    end
  end

  // Payload and product
  always_ff @(posedge clk) begin
    if (load) begin
      tx.block_ok       <= blk.ok;
      tx.data_valid     <= blk.valid;
      tx.voltage_mv     <= $signed(blk.vals[SLOT_V]);
      tx.current_ma     <= $signed(blk.vals[SLOT_I]);
      tx.starter_mv     <= $signed(blk.vals[SLOT_VS]);
      tx.soc_permille   <= $signed(blk.vals[SLOT_SOC]);
      tx.time_to_go_min <= $signed(blk.vals[SLOT_TTG]);
      tx.power_uw       <= $signed(blk.vals[SLOT_V]) * $signed(blk.vals[SLOT_I]);
    end
  end

endmodule

@@ src/label_value_block_parser_core.sv @@
// Label/value block parser core: byte input, one result per checksum byte.
//
// Channel rx carries one text byte per beat (rx_byte). Lines are LABEL TAB
// VALUE LF; CR is ignored. Values of V, I, VS, SOC and TTG are parsed as
// signed decimals, saturated to 32 bits, and buffered for the current block.
// After the label "Checksum" the next byte closes the block: if the 8-bit sum
// of all block bytes is zero, the buffered values are committed.
// Channel tx carries one beat per checksum byte: block_ok, data_valid, all kept
// values and power_uw = voltage_mv * current_ma.
// Throughput: one byte per cycle while rx.ready is high. The block register loads at the
// edge that accepts the checksum byte; the multiplier and output register load from
// the block register once tx can take a beat.
// Reset (rst, synchronous) returns the parser to the label phase, clears the
// sum and buffers, sets time to go to -1 and clears the kept valid flag (data_valid).
// When tx stalls, results wait in the two registers; rx keeps taking bytes
// until both are full, then holds ready low until tx takes a beat.
module label_value_block_parser_core
  import lvb_pkg::*;
#(
  parameter int MAX_VALUE_CHARS = MAX_VALUE_CHARS_DEF,
  parameter int MAX_LABEL_CHARS = MAX_LABEL_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lvb_in_if.sink    rx,
  lvb_out_if.source tx
);

  logic     a_valid;
  logic     b_ready;
  logic     take;
  lvb_blk_t blk;

  assign rx.ready = !a_valid || b_ready;
  assign take     = rx.valid && rx.ready;

  lvb_parser #(
    .MAX_VALUE_CHARS (MAX_VALUE_CHARS),
    .MAX_LABEL_CHARS (MAX_LABEL_CHARS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .b_ready (b_ready),
    .a_valid (a_valid),
    .blk     (blk)
  );

  lvb_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .a_valid (a_valid),
    .blk     (blk),
    .b_ready (b_ready),
    .tx      (tx)
  );

`ifndef SYNTHESIS
  // A committed block always reports the valid flag
  assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.block_ok |-> tx.data_valid)
    else $error("block_ok without data_valid");

  // The valid flag never drops outside reset
  assert property (@(posedge clk) disable iff (rst)
    !$fell(blk.valid))
    else $error("kept valid flag cleared");

  // A taken beat with nothing queued leaves the output empty
  assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.ready && !a_valid |=> !tx.valid)
    else $error("result duplicated on output");
`endif

endmodule
